>>> rtl/go_to_goal_velocity_controller_defines.svh
// Assertion helpers for the controller, the one file that checks its own logic
`ifndef GO_TO_GOAL_VELOCITY_CONTROLLER_DEFINES_SVH
`define GO_TO_GOAL_VELOCITY_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define GTG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("controller check failed");

// Next-cycle implication, sampled on clk, off during rst
`define GTG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("controller check failed");

`endif

>>> rtl/gtg_pkg.sv
package gtg_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_POS_TOL   = 3'd0;
  localparam logic [2:0] REG_MAX_LIN   = 3'd1;
  localparam logic [2:0] REG_MAX_ANG   = 3'd2;
  localparam logic [2:0] REG_ACCEL     = 3'd3;
  localparam logic [2:0] REG_DECEL     = 3'd4;

  localparam int CFG_W        = 31;
  localparam int ANG_STEPS    = 31;
  localparam int ACC_W        = 35;
  localparam int RATE_SHIFT   = 16;

  // Pi in Q2.30
  localparam logic [ACC_W-1:0] PI_Q30 = 35'd3373259426;

  typedef logic signed [32:0]      delta_t;
  typedef logic signed [ACC_W-1:0] angle_t;

  // Arctangent of 2^-i in Q2.30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'h3243F6A8;
      5'd1:  r = 30'h1DAC6705;
      5'd2:  r = 30'h0FADBAFC;
      5'd3:  r = 30'h07F56EA6;
      5'd4:  r = 30'h03FEAB76;
      5'd5:  r = 30'h01FFD55B;
      5'd6:  r = 30'h00FFFAAA;
      5'd7:  r = 30'h007FFF55;
      5'd8:  r = 30'h003FFFEA;
      5'd9:  r = 30'h001FFFFD;
      5'd10: r = 30'h000FFFFF;
      5'd11: r = 30'h0007FFFF;
      5'd12: r = 30'h0003FFFF;
      5'd13: r = 30'h0001FFFF;
      5'd14: r = 30'h0000FFFF;
      5'd15: r = 30'h00007FFF;
      5'd16: r = 30'h00003FFF;
      5'd17: r = 30'h00001FFF;
      5'd18: r = 30'h00000FFF;
      5'd19: r = 30'h000007FF;
      5'd20: r = 30'h000003FF;
      5'd21: r = 30'h000001FF;
      5'd22: r = 30'h000000FF;
      5'd23: r = 30'h0000007F;
      5'd24: r = 30'h0000003F;
      5'd25: r = 30'h0000001F;
      5'd26: r = 30'h0000000F;
      5'd27: r = 30'h00000008;
      5'd28: r = 30'h00000004;
      5'd29: r = 30'h00000002;
      5'd30: r = 30'h00000001;
      default: r = 30'h0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/gtg_mul.sv
module gtg_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  // Register the product every cycle
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> rtl/gtg_isqrt.sv
module gtg_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v;
  logic [34:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [34:0] rem_sh;
  logic [34:0] trial;

  // Bring down two bits and try the next root bit
  assign rem_sh = {rem[32:0], v[63:62]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Digit-by-digit restoring square root, one root bit per cycle
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      v    <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      v <= {v[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[30:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/gtg_cordic.sv
module gtg_cordic (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  gtg_pkg::delta_t     dx,
  input  gtg_pkg::delta_t     dy,
  output logic                done,
  output gtg_pkg::angle_t     acc
);

  import gtg_pkg::*;

  logic signed [35:0] x;
  logic signed [35:0] y;
  logic [4:0]         idx;
  logic               busy;
  logic signed [35:0] xs;
  logic signed [35:0] ys;
  logic signed [35:0] dx_e;
  logic signed [35:0] dy_e;
  angle_t             step;

  assign dx_e = 36'(dx);
  assign dy_e = 36'(dy);
  assign xs   = x >>> idx;
  assign ys   = y >>> idx;
  assign step = angle_t'({5'b0, atan_q30(idx)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        idx <= idx + 5'd1;
        if (idx == 5'(ANG_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Fold the left half plane by pi, then rotate toward the x axis
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      if (dx < 0) begin
        x   <= -dx_e;
        y   <= -dy_e;
        acc <= (dy >= 0) ? angle_t'(PI_Q30) : -angle_t'(PI_Q30);
      end else begin
        x   <= dx_e;
        y   <= dy_e;
        acc <= '0;
      end
    end else if (busy) begin
      if (y > 0) begin
        x   <= x + ys;
        y   <= y - xs;
        acc <= acc + step;
      end else begin
        x   <= x - ys;
        y   <= y + xs;
        acc <= acc - step;
      end
    end
  end

endmodule

>>> rtl/go_to_goal_velocity_controller.sv
// Proportional go-to-goal controller. Each transaction carries a pose, a goal and a time
// step, and yields one velocity command: linear = distance clamped to max_linear_speed,
// angular = twice the wrapped heading error clamped to +-max_angular_speed. When tick_dt
// is nonzero, linear change is limited by accel_rate/decel_rate times tick_dt, angular
// change by accel_rate times tick_dt both ways. Within the stop tolerance the commands
// and the stored velocities go to zero and at_goal is set. One item at a time; the time
// from accept to result depends on the 32-step square root and the 31-step CORDIC that
// share one sequencer, plus the shared multiplier that forms the squares and the rate
// steps. in_ready returns in the same cycle as the result is raised. A finished result
// moves to the output register; while an earlier result there is still waiting on
// out_ready, the sequencer holds in its last state and in_ready stays low.
module go_to_goal_velocity_controller #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] cur_x,
  input  logic [31:0] cur_y,
  input  logic [19:0] cur_yaw,
  input  logic [31:0] goal_x,
  input  logic [31:0] goal_y,
  input  logic [15:0] tick_dt,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] linear_cmd,
  output logic [31:0] angular_cmd,
  output logic        at_goal,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  import gtg_pkg::*;

  localparam int SH = 30 - FRAC_BITS;
  localparam logic [ACC_W-1:0] RND  = ACC_W'(1) << (SH - 1);
  localparam logic [ACC_W-1:0] PI_F = (PI_Q30 + RND) >> SH;

  typedef enum logic [15:0] {
    S_IDLE  = 16'b0000_0000_0000_0001,
    S_SQX   = 16'b0000_0000_0000_0010,
    S_SQY   = 16'b0000_0000_0000_0100,
    S_SUMS  = 16'b0000_0000_0000_1000,
    S_ROOTG = 16'b0000_0000_0001_0000,
    S_ROOT  = 16'b0000_0000_0010_0000,
    S_CHECK = 16'b0000_0000_0100_0000,
    S_ANGLE = 16'b0000_0000_1000_0000,
    S_WRAP  = 16'b0000_0001_0000_0000,
    S_CLMP  = 16'b0000_0010_0000_0000,
    S_UP    = 16'b0000_0100_0000_0000,
    S_DOWN  = 16'b0000_1000_0000_0000,
    S_RLIN  = 16'b0001_0000_0000_0000,
    S_RANG  = 16'b0010_0000_0000_0000,
    S_FIN   = 16'b0100_0000_0000_0000,
    S_DONE  = 16'b1000_0000_0000_0000
  } state_t;

  state_t state;

  // Configuration
  logic [CFG_W-1:0] pos_tol, max_lin, max_ang, accel, decel;

  // Item registers
  delta_t             dx, dy;
  logic signed [19:0] yaw;
  logic [15:0]        dt;
  logic [63:0]        sum;
  logic [31:0]        span;
  logic signed [37:0] err;
  logic signed [32:0] lin;
  logic signed [33:0] ang;
  logic [30:0]        up, down;
  logic [30:0]        last_lin;
  logic signed [31:0] last_ang;
  logic [30:0]        res_lin;
  logic signed [31:0] res_ang;
  logic               res_goal;

  // Output register
  logic [30:0]        out_lin;
  logic signed [31:0] out_ang;
  logic               out_goal;

  // Shared units
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        sq_done, cd_done;
  logic [31:0] root;
  angle_t      acc;

  logic [32:0]        ax, ay;
  logic signed [34:0] bear;
  logic signed [37:0] pi_w;
  logic signed [37:0] two_pi;
  logic signed [38:0] ang2;
  logic signed [38:0] maxa_w;
  logic signed [34:0] dlin;
  logic signed [35:0] dang;

  assign ax     = dx[32] ? 33'(-dx) : 33'(dx);
  assign ay     = dy[32] ? 33'(-dy) : 33'(dy);
  assign bear   = (acc + angle_t'(RND)) >>> SH;
  assign pi_w   = 38'(PI_F);
  assign two_pi = pi_w <<< 1;
  assign ang2   = 39'(err) <<< 1;
  assign maxa_w = 39'(max_ang);
  assign dlin   = 35'(lin) - $signed({4'b0, last_lin});
  assign dang   = 36'(ang) - 36'(last_ang);

  // Select operands for the shared multiplier
  always_comb begin
    mul_b = {1'b0, ax[30:0]};
    mul_a = {1'b0, ax[30:0]};
    priority case (1'b1)
      state[$clog2(S_SQY)]: begin
        mul_a = {1'b0, ay[30:0]};
        mul_b = {1'b0, ay[30:0]};
      end
      state[$clog2(S_CLMP)]: begin
        mul_a = {1'b0, accel};
        mul_b = {16'b0, dt};
      end
      state[$clog2(S_UP)]: begin
        mul_a = {1'b0, decel};
        mul_b = {16'b0, dt};
      end
      default: ;
    endcase
  end

  gtg_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  gtg_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_ROOTG),
    .value (sum),
    .done  (sq_done),
    .root  (root)
  );

  gtg_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start ((state == S_CHECK) && (span > {1'b0, pos_tol})),
    .dx    (dx),
    .dy    (dy),
    .done  (cd_done),
    .acc   (acc)
  );

  assign in_ready    = (state == S_IDLE);
  assign linear_cmd  = out_lin;
  assign angular_cmd = out_ang;
  assign at_goal     = out_goal;

  // Write configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_tol <= 31'd6554;
      max_lin <= 31'd65536;
      max_ang <= 31'd65536;
      accel   <= 31'd65536;
      decel   <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POS_TOL: pos_tol <= cfg_data;
        REG_MAX_LIN: max_lin <= cfg_data;
        REG_MAX_ANG: max_ang <= cfg_data;
        REG_ACCEL:   accel   <= cfg_data;
        REG_DECEL:   decel   <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [30:0] res_lin_next(input logic signed [32:0] v,
                                               input logic [30:0] hi);
    logic [30:0] r;
    if (v < 0) r = '0;
    else if (v > 33'(hi)) r = hi;
    else r = v[30:0];
    return r;
  endfunction

  function automatic logic [31:0] res_ang_next(input logic signed [33:0] v,
                                               input logic [30:0] hi);
    logic signed [33:0] lim;
    logic [31:0] r;
    lim = $signed({3'b0, hi});
    if (v > lim) r = {1'b0, hi};
    else if (v < -lim) r = 32'(-lim);
    else r = v[31:0];
    return r;
  endfunction

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      last_lin  <= '0;
      last_ang  <= '0;
    end else begin
      // Raise the result as it moves out, drop it once taken
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_SQX;
        S_SQX: begin
          if (ax[32:31] != 2'b00 || ay[32:31] != 2'b00) state <= S_CHECK;
          else state <= S_SQY;
        end
        S_SQY:   state <= S_SUMS;
        S_SUMS:  state <= S_ROOTG;
        S_ROOTG: state <= S_ROOT;
        S_ROOT:  if (sq_done) state <= S_CHECK;
        S_CHECK: begin
          if (span <= {1'b0, pos_tol}) begin
            last_lin <= '0;
            last_ang <= '0;
            state    <= S_DONE;
          end else begin
            state <= S_ANGLE;
          end
        end
        S_ANGLE: if (cd_done) state <= S_WRAP;
        S_WRAP:  state <= S_CLMP;
        S_CLMP:  state <= S_UP;
        S_UP:    state <= S_DOWN;
        S_DOWN:  state <= S_RLIN;
        S_RLIN:  state <= S_RANG;
        S_RANG:  state <= S_FIN;
        S_FIN: begin
          last_lin <= 31'(res_lin_next(lin, max_lin));
          last_ang <= 32'(res_ang_next(ang, max_ang));
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          dx  <= 33'(signed'(goal_x)) - 33'(signed'(cur_x));
          dy  <= 33'(signed'(goal_y)) - 33'(signed'(cur_y));
          yaw <= cur_yaw;
          dt  <= tick_dt;
        end
      end
      S_SQX: begin
        if (ax[32:31] != 2'b00 || ay[32:31] != 2'b00) span <= 32'h8000_0000;
      end
      S_SQY:   sum <= prod;
      S_SUMS:  sum <= sum + prod;
      S_ROOT: begin
        if (sq_done) span <= root[31] ? 32'h8000_0000 : root;
      end
      S_CHECK: begin
        if (span <= {1'b0, pos_tol}) begin
          res_lin  <= '0;
          res_ang  <= '0;
          res_goal <= 1'b1;
        end
      end
      S_ANGLE: begin
        if (cd_done) err <= 38'(bear) - 38'(yaw);
      end
      // Wrap the heading error once
      S_WRAP: begin
        if (err > pi_w) err <= err - two_pi;
        else if (err < -pi_w) err <= err + two_pi;
      end
      // Apply gains and the speed limits
      S_CLMP: begin
        lin <= (span > {1'b0, max_lin}) ? 33'(max_lin) : 33'(span);
        if (ang2 > maxa_w) ang <= 34'(max_ang);
        else if (ang2 < -maxa_w) ang <= -34'(max_ang);
        else ang <= 34'(ang2);
      end
      S_UP:    up   <= prod[RATE_SHIFT+30:RATE_SHIFT];
      S_DOWN:  down <= prod[RATE_SHIFT+30:RATE_SHIFT];
      // Limit the change against the previous commands
      S_RLIN: begin
        if (dt != 16'd0) begin
          if (dlin > $signed({4'b0, up})) lin <= 33'({1'b0, last_lin}) + 33'(up);
          else if (dlin < -$signed({4'b0, down}))
            lin <= 33'({1'b0, last_lin}) - 33'(down);
        end
      end
      S_RANG: begin
        if (dt != 16'd0) begin
          if (dang > $signed({5'b0, up})) ang <= 34'(last_ang) + 34'(up);
          else if (dang < -$signed({5'b0, up})) ang <= 34'(last_ang) - 34'(up);
        end
      end
      S_FIN: begin
        res_lin  <= res_lin_next(lin, max_lin);
        res_ang  <= res_ang_next(ang, max_ang);
        res_goal <= 1'b0;
      end
      // Move the finished result to the output register
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_lin  <= res_lin;
          out_ang  <= res_ang;
          out_goal <= res_goal;
        end
      end
      default: ;
    endcase
  end

`include "go_to_goal_velocity_controller_defines.svh"

  `GTG_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
  `GTG_ASSERT_NOW(a_goal_zero, out_valid && at_goal, linear_cmd == '0 && angular_cmd == '0)
  `GTG_ASSERT_NOW(a_cordic_slot, cd_done, state == S_ANGLE)
  `GTG_ASSERT_NOW(a_root_slot, sq_done, state == S_ROOT)

endmodule

>>> sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gtg_pkg::*;

  localparam int FB = 16;
  localparam longint PI_Q30_L = 64'sd3373259426;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LATENCY = 100;
  localparam logic [2:0] REG_NONE = 3'd7;

  typedef struct {
    logic [31:0] cx, cy;
    logic [19:0] yaw;
    logic [31:0] gx, gy;
    logic [15:0] dt;
  } pose_t;

  typedef struct {
    logic [30:0] lin;
    logic [31:0] ang;
    logic        goal;
  } cmd_t;

  // Directed stimulus row; known marks an expectation typed in by hand
  typedef struct {
    pose_t p;
    bit    known;
    cmd_t  c;
  } row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [31:0] cur_x, cur_y, goal_x, goal_y;
  logic [19:0] cur_yaw;
  logic [15:0] tick_dt;
  logic [30:0] linear_cmd;
  logic [31:0] angular_cmd;
  logic at_goal;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [30:0] cfg_data;

  // Predictor copy of registers and velocity history
  longint tol_r, maxl_r, maxa_r, acc_r, dec_r;
  longint prev_lin, prev_ang;

  cmd_t expected_cmds[$];
  int   errors;
  int   idle_cycles;
  bit   rx_noidle, tx_noidle, rx_hold;

  go_to_goal_velocity_controller dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint q30_round(longint a);
    return floor_shift(a + (64'sd1 << (29 - FB)), 30 - FB);
  endfunction

  // CORDIC vectoring heading to the goal
  function automatic longint heading_to(longint dx, longint dy);
    longint x, y, a, xs, ys;
    x = dx; y = dy; a = 0;
    if (dx < 0) begin
      x = -dx; y = -dy;
      a = (dy >= 0) ? PI_Q30_L : -PI_Q30_L;
    end
    for (int i = 0; i < ANG_STEPS; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y > 0) begin
        x += ys; y -= xs; a += longint'(atan_q30(i[4:0]));
      end else begin
        x -= ys; y += xs; a -= longint'(atan_q30(i[4:0]));
      end
    end
    return q30_round(a);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Compute the velocity command for one pose and advance the history
  function automatic cmd_t predict_command(pose_t p);
    cmd_t c;
    longint dx, dy, ax, ay, span, pif, err, lin, ang, up, down, d;
    dx = longint'($signed(p.gx)) - longint'($signed(p.cx));
    dy = longint'($signed(p.gy)) - longint'($signed(p.cy));
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax >= (64'sd1 << 31) || ay >= (64'sd1 << 31)) span = 64'sd1 << 31;
    else begin
      span = int_sqrt(ax * ax + ay * ay);
      if (span > (64'sd1 << 31)) span = 64'sd1 << 31;
    end
    if (span <= tol_r) begin
      prev_lin = 0; prev_ang = 0;
      c.lin = '0; c.ang = '0; c.goal = 1'b1;
      return c;
    end
    pif = q30_round(PI_Q30_L);
    err = heading_to(dx, dy) - longint'($signed(p.yaw));
    if (err > pif) err -= 2 * pif;
    else if (err < -pif) err += 2 * pif;
    lin = clip(span, 0, maxl_r);
    ang = clip(2 * err, -maxa_r, maxa_r);
    if (p.dt != 0) begin
      up = (acc_r * longint'(p.dt)) >>> 16;
      down = (dec_r * longint'(p.dt)) >>> 16;
      d = lin - prev_lin;
      if (d > up) lin = prev_lin + up;
      else if (d < -down) lin = prev_lin - down;
      d = ang - prev_ang;
      if (d > up) ang = prev_ang + up;
      else if (d < -up) ang = prev_ang - up;
    end
    lin = clip(lin, 0, maxl_r);
    ang = clip(ang, -maxa_r, maxa_r);
    prev_lin = lin; prev_ang = ang;
    c.lin = lin[30:0]; c.ang = ang[31:0]; c.goal = 1'b0;
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Write one register while the block is idle
  task automatic write_reg(logic [2:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[30:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_POS_TOL: tol_r = val[30:0];
      REG_MAX_LIN: maxl_r = val[30:0];
      REG_MAX_ANG: maxa_r = val[30:0];
      REG_ACCEL:   acc_r = val[30:0];
      REG_DECEL:   dec_r = val[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drop the input offer and wait until every transaction is out
  task automatic drain_block();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Offer one pose and hold it until the block accepts it
  task automatic send_pose(pose_t p, bit known, cmd_t c);
    cmd_t pred;
    if (!tx_noidle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cur_x <= p.cx; cur_y <= p.cy; cur_yaw <= p.yaw;
    goal_x <= p.gx; goal_y <= p.gy; tick_dt <= p.dt;
    do @(posedge clk); while (!in_ready);
    pred = predict_command(p);
    if (known && (pred.lin != c.lin || pred.ang != c.ang || pred.goal != c.goal))
      report_mismatch("directed row vs predictor", pred.ang, c.ang);
    expected_cmds.push_back(known ? c : pred);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 20 << 16) - (10 << 16);
      default: return $urandom_range(0, 1 << 12) - (1 << 11);
    endcase
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    int m;
    m = $urandom_range(0, 9);
    m = m == 0 ? 0 : (m < 8 ? 1 : 2);
    p.cx = rand_coord(m); p.cy = rand_coord(m);
    p.gx = rand_coord(m); p.gy = rand_coord(m);
    if ($urandom_range(0, 15) == 0) begin
      p.gx = p.cx + $urandom_range(0, 2000) - 1000;
      p.gy = p.cy;
    end
    p.yaw = 20'(int'($urandom_range(0, 823550)) - 411775);
    case ($urandom_range(0, 5))
      0: p.dt = 16'd0;
      1: p.dt = 16'hFFFF;
      default: p.dt = 16'($urandom());
    endcase
    return p;
  endfunction

  // Receiver: random stalls, one long hold-off, check each transaction
  always @(posedge clk) begin
    cmd_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch("unexpected transaction", angular_cmd, 0);
      end else begin
        e = expected_cmds.pop_front();
        if (linear_cmd !== e.lin) report_mismatch("linear_cmd", linear_cmd, e.lin);
        if (angular_cmd !== e.ang)
          report_mismatch("angular_cmd", $signed(angular_cmd), $signed(e.ang));
        if (at_goal !== e.goal) report_mismatch("at_goal", at_goal, e.goal);
      end
    end
  end

  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        rx_hold = 0;
      end else if (!rx_noidle && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 4);
        out_ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    cmd_t none;
    pose_t p;
    errors = 0; idle_cycles = 0;
    rx_noidle = 0; tx_noidle = 0; rx_hold = 0;
    rst = 1'b1;
    in_valid = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    cur_x = '0; cur_y = '0; cur_yaw = '0; goal_x = '0; goal_y = '0; tick_dt = '0;
    tol_r = 6554; maxl_r = 65536; maxa_r = 65536; acc_r = 65536; dec_r = 65536;
    prev_lin = 0; prev_ang = 0;
    none = '{lin: '0, ang: '0, goal: 1'b0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: at goal, tolerance edge, extremes, wrap, folding, saturation
    rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1, '{0, 0, 1}});
    rows.push_back('{'{32'h80000000, 32'h80000000, 20'sd411775, 32'h80000000,
                       32'h80000000, 16'hFFFF}, 1, '{0, 0, 1}});
    rows.push_back('{'{0, 0, 0, 6554, 0, 0}, 1, '{0, 0, 1}});
    rows.push_back('{'{0, 0, 0, 6555, 0, 0}, 0, none});
    rows.push_back('{'{0, 0, 0, 32'h7FFFFFFF, 0, 0}, 0, none});
    rows.push_back('{'{32'h7FFFFFFF, 32'h7FFFFFFF, -20'sd411775, 32'h80000000,
                       32'h80000000, 16'hFFFF}, 0, none});
    rows.push_back('{'{0, 0, 20'sd411775, -32'sd65536, 0, 0}, 0, none});
    rows.push_back('{'{0, 0, -20'sd411775, -32'sd65536, -32'sd1, 1}, 0, none});
    rows.push_back('{'{0, 0, 20'sd205887, 0, 32'sd65536, 100}, 0, none});
    rows.push_back('{'{0, 0, -20'sd205887, 0, -32'sd65536, 16'h8000}, 0, none});
    rows.push_back('{'{5, 5, 0, 32'sd300000, 32'sd300000, 16'hFFFF}, 0, none});
    rows.push_back('{'{0, 0, 0, -32'sd65536, 32'sd65536, 16'h0001}, 0, none});
    foreach (rows[i]) begin
      r = rows[i];
      send_pose(r.p, r.known, r.c);
    end

    // Extreme settings: zero limits, then full-scale limits
    drain_block();
    write_reg(REG_POS_TOL, 0);
    write_reg(REG_MAX_LIN, 0);
    write_reg(REG_MAX_ANG, 0);
    write_reg(REG_ACCEL, 0);
    write_reg(REG_DECEL, 0);
    write_reg(REG_NONE, 12345);
    rows.delete();
    rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1, '{0, 0, 1}});
    rows.push_back('{'{0, 0, 0, 1, 0, 16'hFFFF}, 1, '{0, 0, 0}});
    foreach (rows[i]) send_pose(rows[i].p, rows[i].known, rows[i].c);
    drain_block();
    write_reg(REG_POS_TOL, 31'h7FFFFFFF);
    write_reg(REG_MAX_LIN, 31'h7FFFFFFF);
    write_reg(REG_MAX_ANG, 31'h7FFFFFFF);
    write_reg(REG_ACCEL, 31'h7FFFFFFF);
    write_reg(REG_DECEL, 31'h7FFFFFFF);
    send_pose('{0, 0, 0, 32'h7FFFFFFF, 0, 1}, 1, '{0, 0, 1});
    send_pose('{0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1}, 0, none);
    drain_block();
    write_reg(REG_POS_TOL, 0);

    // Random phases under several settings
    for (int ph = 0; ph < 6; ph++) begin
      drain_block();
      write_reg(REG_POS_TOL, ph == 5 ? 31'h7FFFFFFF : $urandom_range(0, 1 << 14));
      write_reg(REG_MAX_LIN, ph == 0 ? 31'h7FFFFFFF : $urandom_range(0, 1 << 20));
      write_reg(REG_MAX_ANG, ph == 0 ? 31'h7FFFFFFF : $urandom_range(0, 1 << 19));
      write_reg(REG_ACCEL, ph == 1 ? 0 : $urandom_range(0, 1 << 22));
      write_reg(REG_DECEL, ph == 1 ? 31'h7FFFFFFF : $urandom_range(0, 1 << 22));
      if (ph == 2) rx_hold = 1;
      if (ph == 5) begin
        rx_noidle = 1; tx_noidle = 1;
      end
      for (int k = 0; k < 240; k++) begin
        p = rand_pose();
        send_pose(p, 0, none);
      end
    end

    drain_block();
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/gtg_pkg.sv
rtl/gtg_mul.sv
rtl/gtg_isqrt.sv
rtl/gtg_cordic.sv
rtl/go_to_goal_velocity_controller.sv
sim/tb.sv
